// ===== sv/pve_pkg.sv =====
package pve_pkg;

  localparam int RAW_W   = 24;
  localparam int POS_W   = 32;
  localparam int VEL_W   = 40;
  localparam int SCALE_W = 32;
  localparam int COEF_W  = 32;
  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;

  // Filter operand: a velocity or a sum of two, possibly negated, split into two halves
  // so that each pass through the multiplier stays narrow.
  localparam int OP_W    = VEL_W + 2;
  localparam int HALF_W  = OP_W / 2;
  localparam int PROD_W  = HALF_W + 1 + COEF_W + 1;

  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd65536;

  // One row of the history memory, one row per axis.
  typedef struct packed {
    logic signed [POS_W-1:0] p1;
    logic signed [POS_W-1:0] p2;
    logic signed [VEL_W-1:0] x1;
    logic signed [VEL_W-1:0] x2;
    logic signed [VEL_W-1:0] x3;
    logic signed [VEL_W-1:0] y1;
    logic signed [VEL_W-1:0] y2;
    logic signed [VEL_W-1:0] y3;
  } pve_row_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic hi_sel;
  } pve_mac_ctl_t;

  // Rounds num * 1e-7 to a fixed-point coefficient with frac fraction bits.
  function automatic logic [COEF_W-1:0] pve_qcoef(input longint unsigned num,
                                                  input int unsigned frac);
    longint unsigned q;
    q = ((num << frac) + 64'd5000000) / 64'd10000000;
    return q[COEF_W-1:0];
  endfunction

endpackage

// ===== sv/pve_ram.sv =====
module pve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pve_mac.sv =====
module pve_mac import pve_pkg::*; #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pve_mac_ctl_t            ctl,
  input  logic signed [OP_W-1:0]  operand,
  input  logic [COEF_W-1:0]       coef,
  output logic signed [VEL_W-1:0] result
);

  localparam int ACC_W = COEF_FRAC_BITS + 46;
  localparam int SH_W  = ACC_W - COEF_FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_INIT = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [HALF_W:0]      factor;
  logic signed [PROD_W-1:0]    prod_c;
  logic signed [PROD_W-1:0]    mul_r;
  logic                        mul_vld_r;
  logic                        mul_hi_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [ACC_W-1:0]     acc_add;
  logic signed [SH_W-1:0]      shifted;

  // The upper half carries the sign; the lower half is a plain magnitude.
  assign factor = ctl.hi_sel ? $signed({operand[OP_W-1], operand[OP_W-1:HALF_W]})
                             : $signed({1'b0, operand[HALF_W-1:0]});
  assign prod_c = PROD_W'(factor) * PROD_W'($signed({1'b0, coef}));

  assign acc_add = mul_hi_r ? (ACC_W'(mul_r) <<< HALF_W) : ACC_W'(mul_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      mul_hi_r  <= 1'b0;
    end else begin
      mul_vld_r <= ctl.mul_en;
      mul_hi_r  <= ctl.hi_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_r <= prod_c;
    end
    if (ctl.clr) begin
      acc_r <= $signed(ACC_INIT);
    end else if (mul_vld_r) begin
      acc_r <= acc_r + acc_add;
    end
  end

  // The rounding constant was preloaded, so a plain arithmetic shift rounds half up.
  assign shifted = $signed(acc_r[ACC_W-1:COEF_FRAC_BITS]);

  always_comb begin
    if (shifted[SH_W-1:VEL_W-1] == '0 || shifted[SH_W-1:VEL_W-1] == '1) begin
      result = shifted[VEL_W-1:0];
    end else if (shifted[SH_W-1]) begin
      result = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(VEL_W-1){1'b1}}};
    end
  end

endmodule

// ===== sv/position_velocity_estimator_core.sv =====
// Items are taken one at a time; the next is accepted once the last is in the output
// register. Each axis takes a read of its history row, position scaling, the velocity
// difference and passes of the shared 22x33 multiplier that runs the low-pass.
// The next item is taken while a finished result still waits in the output register.
// Synchronous reset (rst_n low) clears all history, which then reads as zero, sets
// position_scale to 1.0 and empties the output register.
module position_velocity_estimator_core import pve_pkg::*; #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SCALE_W-1:0]      cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RAW_W-1:0] in_raw_x,
  input  logic signed [RAW_W-1:0] in_raw_y,
  input  logic signed [RAW_W-1:0] in_raw_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  output logic signed [VEL_W-1:0] out_vel_x,
  output logic signed [VEL_W-1:0] out_vel_y,
  output logic signed [VEL_W-1:0] out_vel_z
);

  localparam logic [COEF_W-1:0] COEF_B0 = pve_qcoef(64'd2196, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] COEF_B1 = pve_qcoef(64'd6588, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] COEF_A1 = pve_qcoef(64'd27488000, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] COEF_A2 = pve_qcoef(64'd25282000, COEF_FRAC_BITS);
  localparam logic [COEF_W-1:0] COEF_A3 = pve_qcoef(64'd7776000, COEF_FRAC_BITS);

  localparam int MAC_TERMS = 5;
  localparam int MAC_STEPS = 2 * MAC_TERMS;
  localparam int STEP_W    = $clog2(MAC_STEPS + 1);
  localparam int TERM_W    = STEP_W - 1;
  localparam int ROW_W     = $bits(pve_row_t);
  localparam int SPROD_W   = RAW_W + 1 + SCALE_W + 1;
  localparam int VD_W      = POS_W + 4;
  localparam int V500_W    = VD_W + 9;

  localparam logic [TERM_W-1:0] TERM_B0 = 3'd0;
  localparam logic [TERM_W-1:0] TERM_B1 = 3'd1;
  localparam logic [TERM_W-1:0] TERM_A1 = 3'd2;
  localparam logic [TERM_W-1:0] TERM_A2 = 3'd3;
  localparam logic [TERM_W-1:0] TERM_A3 = 3'd4;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_POS  = 3'd2;
  localparam logic [2:0] S_VEL  = 3'd3;
  localparam logic [2:0] S_MAC  = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [AXIS_W-1:0]   axis_r, axis_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [AXES-1:0]     valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SCALE_W-1:0]  scale_r, scale_nxt;
  logic                out_load;

  logic signed [RAW_W-1:0]   raw_x_r, raw_y_r, raw_z_r;
  logic signed [SPROD_W-1:0] prod_r;
  logic signed [POS_W-1:0]   p_r;
  logic signed [VEL_W-1:0]   v_r;
  logic signed [POS_W-1:0]   res_pos_r [AXES];
  logic signed [VEL_W-1:0]   res_vel_r [AXES];
  logic signed [POS_W-1:0]   out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [VEL_W-1:0]   out_vel_x_r, out_vel_y_r, out_vel_z_r;

  logic signed [RAW_W:0]     remap;
  logic signed [SPROD_W-1:0] prod_c;
  logic signed [SPROD_W-1:0] prod_rnd;
  logic signed [SPROD_W-1:0] prod_sh;
  logic signed [POS_W-1:0]   p_c;
  logic signed [VD_W-1:0]    vd;
  logic signed [V500_W-1:0]  v500;
  logic signed [VEL_W-1:0]   v_c;

  logic [ROW_W-1:0]          ram_rd_data;
  pve_row_t                  row;
  pve_row_t                  row_new;
  pve_mac_ctl_t              mac_ctl;
  logic [TERM_W-1:0]         term;
  logic signed [OP_W-1:0]    mac_op;
  logic [COEF_W-1:0]         mac_coef;
  logic signed [VEL_W-1:0]   mac_y;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_ready;
    scale_nxt     = (cfg_valid && cfg_ready) ? cfg_data : scale_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RD;
          axis_nxt  = AXIS_X;
        end
      end
      S_RD:  state_nxt = S_POS;
      S_POS: state_nxt = S_VEL;
      S_VEL: begin
        state_nxt = S_MAC;
        step_nxt  = '0;
      end
      S_MAC: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MAC_STEPS)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        valid_nxt[axis_r] = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_OUT;
        end else begin
          axis_nxt  = axis_r + AXIS_W'(1);
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      step_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      scale_r     <= SCALE_RST;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      scale_r     <= scale_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // History memory: one row per axis, read in S_RD and written back in S_RES.
  // A row never written since reset reads as zero.
  // ---------------------------------------------------------------------------
  pve_ram #(
    .WIDTH (ROW_W),
    .DEPTH (AXES)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (state_r == S_RES),
    .wr_addr (axis_r),
    .wr_data (row_new),
    .rd_en   (state_r == S_RD),
    .rd_addr (axis_r),
    .rd_data (ram_rd_data)
  );

  assign row = valid_r[axis_r] ? pve_row_t'(ram_rd_data) : '0;

  always_comb begin
    row_new    = row;
    row_new.p1 = p_r;
    row_new.p2 = row.p1;
    row_new.x1 = v_r;
    row_new.x2 = row.x1;
    row_new.x3 = row.x2;
    row_new.y1 = mac_y;
    row_new.y2 = row.y1;
    row_new.y3 = row.y2;
  end

  // ---------------------------------------------------------------------------
  // Position scaling and backward difference
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (axis_r)
      AXIS_X:  remap = {raw_x_r[RAW_W-1], raw_x_r};
      AXIS_Y:  remap = -$signed({raw_z_r[RAW_W-1], raw_z_r});
      AXIS_Z:  remap = {raw_y_r[RAW_W-1], raw_y_r};
      default: remap = '0;
    endcase
  end

  assign prod_c   = SPROD_W'(remap) * SPROD_W'($signed({1'b0, scale_r}));
  assign prod_rnd = prod_r + SPROD_W'(32'sd32768);
  assign prod_sh  = prod_rnd >>> 16;

  always_comb begin
    if (prod_sh[SPROD_W-1:POS_W-1] == '0 || prod_sh[SPROD_W-1:POS_W-1] == '1) begin
      p_c = prod_sh[POS_W-1:0];
    end else if (prod_sh[SPROD_W-1]) begin
      p_c = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      p_c = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // 500 times the difference, as 512 - 8 - 4.
  assign vd   = (VD_W'(p_r) <<< 1) + VD_W'(p_r) - (VD_W'(row.p1) <<< 2) + VD_W'(row.p2);
  assign v500 = (V500_W'(vd) <<< 9) - (V500_W'(vd) <<< 3) - (V500_W'(vd) <<< 2);

  always_comb begin
    if (v500[V500_W-1:VEL_W-1] == '0 || v500[V500_W-1:VEL_W-1] == '1) begin
      v_c = v500[VEL_W-1:0];
    end else if (v500[V500_W-1]) begin
      v_c = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      v_c = {1'b0, {(VEL_W-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Low-pass filter: five terms, each in two halves through the shared multiplier.
  // The feedback term with the minus sign is negated before it is multiplied.
  // ---------------------------------------------------------------------------
  assign term = step_r[STEP_W-1:1];

  always_comb begin
    unique case (term)
      TERM_B0: begin
        mac_op   = OP_W'(v_r) + OP_W'(row.x3);
        mac_coef = COEF_B0;
      end
      TERM_B1: begin
        mac_op   = OP_W'(row.x1) + OP_W'(row.x2);
        mac_coef = COEF_B1;
      end
      TERM_A1: begin
        mac_op   = OP_W'(row.y1);
        mac_coef = COEF_A1;
      end
      TERM_A2: begin
        mac_op   = -OP_W'(row.y2);
        mac_coef = COEF_A2;
      end
      TERM_A3: begin
        mac_op   = OP_W'(row.y3);
        mac_coef = COEF_A3;
      end
      default: begin
        mac_op   = '0;
        mac_coef = '0;
      end
    endcase
  end

  assign mac_ctl.clr    = (state_r == S_VEL);
  assign mac_ctl.mul_en = (state_r == S_MAC) && (step_r != STEP_W'(MAC_STEPS));
  assign mac_ctl.hi_sel = step_r[0];

  pve_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .operand (mac_op),
    .coef    (mac_coef),
    .result  (mac_y)
  );

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_x_r <= in_raw_x;
      raw_y_r <= in_raw_y;
      raw_z_r <= in_raw_z;
    end
    if (state_r == S_RD) begin
      prod_r <= prod_c;
    end
    if (state_r == S_POS) begin
      p_r <= p_c;
    end
    if (state_r == S_VEL) begin
      v_r <= v_c;
    end
    if (state_r == S_RES) begin
      res_pos_r[axis_r] <= p_r;
      res_vel_r[axis_r] <= mac_y;
    end
    if (out_load) begin
      out_pos_x_r <= res_pos_r[0];
      out_pos_y_r <= res_pos_r[1];
      out_pos_z_r <= res_pos_r[2];
      out_vel_x_r <= res_vel_r[0];
      out_vel_y_r <= res_vel_r[1];
      out_vel_z_r <= res_vel_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_pos_z = out_pos_z_r;
  assign out_vel_x = out_vel_x_r;
  assign out_vel_y = out_vel_y_r;
  assign out_vel_z = out_vel_z_r;

endmodule

// ===== sv/pve_checker.sv =====
module pve_checker import pve_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] out_pos_x,
  input logic signed [VEL_W-1:0] out_vel_z
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_vel_z))
    else $error("result item dropped or changed while stalled");

  // Only one item is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("new item accepted while one is in work");

  // A fresh result appears exactly when the block turns ready again.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result item presented while an item is still in work");

endmodule

bind position_velocity_estimator_core pve_checker u_pve_checker (.*);

// ===== tb/tb_position_velocity_estimator_core.sv =====
module tb_position_velocity_estimator_core import pve_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COEF_FRAC_BITS = 28;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 60;

  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN = -(64'sd1 <<< (POS_W - 1));
  localparam longint VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint VEL_MIN = -(64'sd1 <<< (VEL_W - 1));
  localparam longint RAW_MAX = (64'sd1 <<< (RAW_W - 1)) - 1;
  localparam longint RAW_MIN = -(64'sd1 <<< (RAW_W - 1));

  localparam logic signed [RAW_W-1:0] RAW_HI = {1'b0, {(RAW_W - 1){1'b1}}};
  localparam logic signed [RAW_W-1:0] RAW_LO = {1'b1, {(RAW_W - 1){1'b0}}};

  typedef struct packed {
    logic [AXES-1:0][POS_W-1:0] pos;
    logic [AXES-1:0][VEL_W-1:0] vel;
  } estimate_t;

  // Tracks the scaled positions and the filter histories of all three axes and
  // holds the estimates that are still to come out of the block.
  class motion_tracker;
    bit [SCALE_W-1:0] scale;
    longint last_pos[AXES];
    longint older_pos[AXES];
    longint vel_in[AXES][3];
    longint vel_out[AXES][3];
    logic signed [127:0] cb0, cb1, ca1, ca2, ca3;
    estimate_t queued[$];
    int unsigned failures;
    int unsigned seen;

    function new();
      scale = SCALE_RST;
      cb0 = q_coef(2196);
      cb1 = q_coef(6588);
      ca1 = q_coef(27488000);
      ca2 = q_coef(25282000);
      ca3 = q_coef(7776000);
    endfunction

    // The argument is the coefficient in units of 1e-7.
    static function longint q_coef(longint unsigned tenth_micro);
      return ((tenth_micro << COEF_FRAC_BITS) + 64'd5000000) / 64'd10000000;
    endfunction

    static function longint bound(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void take_sample(input logic signed [RAW_W-1:0] rx,
                              input logic signed [RAW_W-1:0] ry,
                              input logic signed [RAW_W-1:0] rz);
      longint axis_in[AXES];
      longint gain, prod, p, v, y;
      logic signed [127:0] pair_new, pair_mid, y1, y2, y3, acc, half;
      estimate_t want;
      gain = scale;
      half = 1;
      half = half <<< (COEF_FRAC_BITS - 1);
      axis_in[0] = rx;
      axis_in[1] = rz;
      axis_in[1] = -axis_in[1];
      axis_in[2] = ry;
      for (int a = 0; a < AXES; a++) begin
        prod = axis_in[a] * gain + 64'sd32768;
        p = bound(prod >>> 16, POS_MIN, POS_MAX);
        v = bound((3 * p - 4 * last_pos[a] + older_pos[a]) * 500, VEL_MIN, VEL_MAX);
        pair_new = v + vel_in[a][2];
        pair_mid = vel_in[a][0] + vel_in[a][1];
        y1 = vel_out[a][0];
        y2 = vel_out[a][1];
        y3 = vel_out[a][2];
        acc = pair_new * cb0 + pair_mid * cb1 + y1 * ca1 - y2 * ca2 + y3 * ca3 + half;
        acc = acc >>> COEF_FRAC_BITS;
        if (acc > VEL_MAX) acc = VEL_MAX;
        if (acc < VEL_MIN) acc = VEL_MIN;
        y = longint'(acc);
        older_pos[a] = last_pos[a];
        last_pos[a] = p;
        vel_in[a][2] = vel_in[a][1];
        vel_in[a][1] = vel_in[a][0];
        vel_in[a][0] = v;
        vel_out[a][2] = vel_out[a][1];
        vel_out[a][1] = vel_out[a][0];
        vel_out[a][0] = y;
        want.pos[a] = p[POS_W-1:0];
        want.vel[a] = y[VEL_W-1:0];
      end
      queued.push_back(want);
    endfunction

    function void check_estimate(estimate_t got);
      estimate_t want;
      string tags = "xyz";
      seen++;
      if (queued.size() == 0) begin
        flag($sformatf("result %0d arrived with no item outstanding", seen));
        return;
      end
      want = queued.pop_front();
      for (int a = 0; a < AXES; a++) begin
        if (got.pos[a] !== want.pos[a])
          flag($sformatf("result %0d pos_%c: expected %0d, got %0d", seen, tags[a],
                         $signed(want.pos[a]), $signed(got.pos[a])));
        if (got.vel[a] !== want.vel[a])
          flag($sformatf("result %0d vel_%c: expected %0d, got %0d", seen, tags[a],
                         $signed(want.vel[a]), $signed(got.vel[a])));
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [SCALE_W-1:0]      cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [RAW_W-1:0] in_raw_x;
  logic signed [RAW_W-1:0] in_raw_y;
  logic signed [RAW_W-1:0] in_raw_z;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;
  logic signed [VEL_W-1:0] out_vel_x;
  logic signed [VEL_W-1:0] out_vel_y;
  logic signed [VEL_W-1:0] out_vel_z;

  motion_tracker board;
  estimate_t     observed;
  bit            bursts_on = 1'b1;
  int unsigned   quiet_cycles;

  position_velocity_estimator_core #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_raw_x (in_raw_x),
    .in_raw_y (in_raw_y),
    .in_raw_z (in_raw_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x),
    .out_vel_y(out_vel_y),
    .out_vel_z(out_vel_z)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: holds off in random bursts while bursts are enabled.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (bursts_on && rst_n && $urandom_range(0, 19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed.pos = {out_pos_z, out_pos_y, out_pos_x};
      observed.vel = {out_vel_z, out_vel_y, out_vel_x};
      board.check_estimate(observed);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("position_velocity_estimator_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [RAW_W-1:0] x,
                             input logic signed [RAW_W-1:0] y,
                             input logic signed [RAW_W-1:0] z);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_x <= x;
    in_raw_y <= y;
    in_raw_z <= z;
    do @(posedge clk); while (!in_ready);
    board.take_sample(x, y, z);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.queued.size() != 0);
    @(negedge clk);
  endtask

  task automatic set_scale(input logic [SCALE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.scale = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly smooth trajectories of varying speed, broken now and then by jumps to
  // arbitrary or extreme positions, from which the motion carries on.
  task automatic run_motion(input int count);
    longint track[AXES];
    logic signed [RAW_W-1:0] sample[AXES];
    bit [31:0] noise;
    int amp;
    int pick;
    amp = 16;
    for (int a = 0; a < AXES; a++) begin
      noise = $urandom;
      sample[a] = noise[RAW_W-1:0];
      track[a] = sample[a];
    end
    repeat (count) begin
      if ($urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 3))
          0: amp = 4;
          1: amp = 256;
          2: amp = 8192;
          default: amp = 262144;
        endcase
      end
      pick = $urandom_range(0, 9);
      for (int a = 0; a < AXES; a++) begin
        if (pick < 7) begin
          track[a] = track[a] + longint'($urandom_range(0, 2 * amp)) - amp;
          track[a] = motion_tracker::bound(track[a], RAW_MIN, RAW_MAX);
          sample[a] = RAW_W'(track[a]);
        end else if (pick < 9) begin
          noise = $urandom;
          sample[a] = noise[RAW_W-1:0];
          track[a] = sample[a];
        end else begin
          case ($urandom_range(0, 3))
            0: sample[a] = RAW_HI;
            1: sample[a] = RAW_LO;
            2: sample[a] = '0;
            default: sample[a] = '1;
          endcase
          track[a] = sample[a];
        end
      end
      send_sample(sample[0], sample[1], sample[2]);
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_x = '0;
    in_raw_y = '0;
    in_raw_z = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset scale of 1.0: field extremes and sign changes.
    send_sample('0, '0, '0);
    send_sample(RAW_HI, RAW_HI, RAW_HI);
    send_sample(RAW_LO, RAW_LO, RAW_LO);
    send_sample(RAW_HI, RAW_LO, RAW_LO);
    send_sample(RAW_W'(-1), RAW_W'(-1), RAW_W'(-1));
    send_sample(RAW_LO, RAW_HI, RAW_HI);
    send_sample(RAW_W'(1), RAW_W'(-1), RAW_W'(1));

    // Full scale: positions saturate and the raw velocity overflows.
    drain();
    set_scale('1);
    send_sample(RAW_HI, RAW_LO, RAW_LO);
    send_sample(RAW_LO, RAW_HI, RAW_HI);
    send_sample(RAW_HI, RAW_LO, RAW_LO);
    send_sample('0, '0, '0);
    send_sample(RAW_HI, RAW_HI, RAW_HI);

    // A zero scale forces every position to zero.
    drain();
    set_scale('0);
    send_sample(RAW_HI, RAW_LO, RAW_HI);
    send_sample(RAW_W'(-5), RAW_W'(7), RAW_W'(-9));

    // Smallest scale: rounding ties go upwards.
    drain();
    set_scale(32'd1);
    send_sample(RAW_W'(32768), RAW_W'(-32768), RAW_W'(32767));
    send_sample(RAW_W'(-32769), RAW_W'(65535), RAW_W'(-65536));
    send_sample(RAW_HI, RAW_LO, RAW_W'(-1));

    drain();
    set_scale($urandom);
    run_motion(170);
    drain();
    set_scale('1);
    run_motion(170);
    drain();
    set_scale($urandom_range(32768, 131072));
    run_motion(170);
    drain();
    set_scale(32'd1);
    run_motion(170);
    drain();
    set_scale('0);
    run_motion(170);
    drain();
    set_scale($urandom_range(1, 65535));
    run_motion(170);

    // The last stretch runs at full rate on both sides.
    drain();
    bursts_on = 1'b0;
    set_scale(SCALE_RST);
    run_motion(130);

    in_valid <= 1'b0;
    while (board.queued.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.queued.size() != 0)
      board.flag($sformatf("%0d results never arrived", board.queued.size()));
    if (board.failures == 0) begin
      $display("position_velocity_estimator_core test passed");
    end else begin
      $display("position_velocity_estimator_core test failed");
    end
    $finish;
  end

endmodule
